// File: rtl/deq_pkg.sv
// Shared types and constants of the double-ended queue.
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_QUERY      = 3'd4;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [4:0]               count;
    logic                     is_empty;
    logic                     error;
  } deq_out_t;

  typedef struct packed {
    logic exec;
    logic rd;
    logic load;
  } deq_ctl_t;

  typedef struct packed {
    logic out_free;
  } deq_sts_t;

endpackage

// File: rtl/deq_ram.sv
// Generic RAM: one write port, two registered read ports.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/deq_ctrl.sv
// Sequencer of the double-ended queue: accept, read, deliver.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  deq_pkg::deq_sts_t sts,
  output deq_pkg::deq_ctl_t ctl
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          ctl.exec   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        ctl.rd     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold the read data until the result register frees up
        if (sts.out_free) begin
          ctl.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign cmd_ready = (state == ST_IDLE);

`ifndef ASSERT_OFF
  a_exec_only_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> (state == ST_READ))
    else $error("command executed outside idle");
  a_read_then_done: assert property (@(posedge clk) disable iff (rst)
    ctl.rd |=> (state == ST_DONE) && !cmd_ready)
    else $error("read not followed by delivery stage");
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> sts.out_free)
    else $error("result loaded into a busy register");
`endif

endmodule

// File: rtl/deq_dp.sv
// Datapath of the double-ended queue: pointers, count, slot RAM, result register.
module deq_dp (
  input  logic              clk,
  input  logic              rst,
  input  deq_pkg::deq_in_t  cmd_data,
  input  deq_pkg::deq_ctl_t ctl,
  output deq_pkg::deq_sts_t sts,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output deq_pkg::deq_out_t rsp_data
);
  import deq_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  logic [IDX_W-1:0]  front_q, front_next;
  logic [CNT_W-1:0]  count_q, count_next;
  logic              err_q, err_next;
  logic              full, empty;
  logic [IDX_W-1:0]  front_dec, front_inc, tail_idx, back_idx;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] rdata_a, rdata_b;

  // Fold a sum below twice the depth back into a slot number.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
    return r[IDX_W-1:0];
  endfunction

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign tail_idx  = wrap_idx(SUM_W'(front_q) + SUM_W'(count_q));
  // garbage when empty; the result then shows the empty marker instead
  assign back_idx  = wrap_idx(SUM_W'(front_q) + SUM_W'(count_q - 1'b1));

  always_comb begin
    we         = 1'b0;
    waddr      = tail_idx;
    front_next = front_q;
    count_next = count_q;
    err_next   = 1'b0;
    unique case (cmd_data.command)
      CMD_PUSH_BACK: begin
        if (full) begin
          err_next = 1'b1;
        end else begin
          we         = ctl.exec;
          count_next = count_q + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          err_next = 1'b1;
        end else begin
          we         = ctl.exec;
          waddr      = front_dec;
          front_next = front_dec;
          count_next = count_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          err_next = 1'b1;
        end else begin
          front_next = front_inc;
          count_next = count_q - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          err_next = 1'b1;
        end else begin
          count_next = count_q - 1'b1;
        end
      end
      default: ;  // query and unused codes change nothing
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_q <= '0;
      count_q <= '0;
    end else if (ctl.exec) begin
      front_q <= front_next;
      count_q <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      err_q <= err_next;
    end
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (cmd_data.value),
    .re      (ctl.rd),
    .raddr_a (front_q),
    .raddr_b (back_idx),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign sts.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rsp_data.front_value <= empty ? '1 : rdata_a;
      rsp_data.back_value  <= empty ? '1 : rdata_b;
      rsp_data.count       <= 5'(count_q);
      rsp_data.is_empty    <= empty;
      rsp_data.error       <= err_q;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= CNT_W'(DEPTH))
    else $error("stored count beyond depth");
  a_error_no_change: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && err_next |=> $stable(count_q) && $stable(front_q))
    else $error("failed command changed the queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && we |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the count");
  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> rsp_data.is_empty == (rsp_data.count == '0))
    else $error("empty flag disagrees with count");
`endif

endmodule

// File: rtl/double_ended_queue.sv
// Top level of the double-ended queue.
// Double-ended queue of up to 16 signed 32-bit values in a ring of RAM slots.
// Each command beat (push back, push front, pop front, pop back, query) gives
// one result beat with the front and back values (-1 when empty), the count,
// an empty flag and an error flag for a pop on empty or a push on full. A
// command is accepted in idle, where the pointers are updated and the slot
// is written; the front and back slots are then read through the registered
// read ports, and the result register is loaded once it is free. No new
// command is taken until the result of the last one is loaded. The result
// register lets the next command be accepted while a result still waits.
// Slots need no clearing after reset: only slots holding stored values are shown.
module double_ended_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  deq_pkg::deq_in_t  cmd_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output deq_pkg::deq_out_t rsp_data
);
  import deq_pkg::*;

  deq_ctl_t ctl;
  deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  deq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd_data),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

// File: bench/double_ended_queue_test.sv
// Self-checking testbench for the double-ended queue: directed edge cases, then random traffic.
`timescale 1ns / 1ps
module double_ended_queue_test;
  import deq_pkg::*;

  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic     clk;
  logic     rst;
  logic     cmd_valid;
  logic     cmd_ready;
  deq_in_t  cmd_data;
  logic     rsp_valid;
  logic     rsp_ready;
  deq_out_t rsp_data;

  double_ended_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  // Shadow copy of the ring contents, head slot and fill level.
  logic signed [DATA_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]         head;
  logic [CNT_W-1:0]         fill;
  deq_out_t                 due_status [$];

  int mismatches  = 0;
  int rsp_beats   = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Apply one command to the shadow state and return the status it leaves.
  function automatic deq_out_t next_status(deq_in_t item);
    deq_out_t         st;
    logic [IDX_W-1:0] tail;
    st = '0;
    case (item.command)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          st.error = 1'b1;
        end else begin
          if (item.command == CMD_PUSH_BACK) begin
            tail = head + fill[IDX_W-1:0];
            ring[tail] = item.value;
          end else begin
            head = head - 1'b1;
            ring[head] = item.value;
          end
          fill = fill + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == 0) begin
          st.error = 1'b1;
        end else begin
          if (item.command == CMD_POP_FRONT) head = head + 1'b1;
          fill = fill - 1'b1;
        end
      end
      default: ;
    endcase
    if (fill == 0) begin
      st.front_value = '1;
      st.back_value  = '1;
      st.is_empty    = 1'b1;
    end else begin
      tail = head + fill[IDX_W-1:0] - 1'b1;
      st.front_value = ring[head];
      st.back_value  = ring[tail];
    end
    st.count = fill;
    return st;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_cmd(input logic [2:0] cmd, input logic signed [DATA_W-1:0] val);
    int      gap;
    deq_in_t item;
    item.command = cmd;
    item.value   = val;
    gap = draw_gap(tx_idle_pct);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid = 1'b1;
    cmd_data  = item;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    due_status.push_back(next_status(item));
  endtask

  // Result sink: stall at random once reset is over.
  initial begin : rsp_sink
    int hold;
    hold = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_ready = 1'b0;
        hold--;
      end else begin
        rsp_ready = 1'b1;
        hold = draw_gap(rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_rsp
    deq_out_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_beats++;
      if (due_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: result with nothing outstanding", rsp_beats);
      end else begin
        want = due_status.pop_front();
        if (rsp_data.front_value !== want.front_value ||
            rsp_data.back_value  !== want.back_value  ||
            rsp_data.count       !== want.count       ||
            rsp_data.is_empty    !== want.is_empty    ||
            rsp_data.error       !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected front %0d back %0d count %0d empty %0b error %0b",
                     rsp_beats, want.front_value, want.back_value, want.count,
                     want.is_empty, want.error,
                     "\n         got      front %0d back %0d count %0d empty %0b error %0b",
                     rsp_data.front_value, rsp_data.back_value, rsp_data.count,
                     rsp_data.is_empty, rsp_data.error);
        end
      end
    end
  end

  // Pops and queries against an empty queue, including an unused code.
  task automatic test_empty_queue();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    issue_cmd(CMD_QUERY, draw_value());
    issue_cmd(CMD_POP_FRONT, draw_value());
    issue_cmd(CMD_POP_BACK, draw_value());
    issue_cmd(CMD_UNUSED_HI, draw_value());
  endtask

  // Wrap the head below slot zero, fill up, overflow from both ends, pop from both ends.
  task automatic test_full_queue();
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    issue_cmd(CMD_PUSH_FRONT, VAL_MAX);
    issue_cmd(CMD_PUSH_BACK, VAL_MIN);
    repeat (DEPTH - 2) issue_cmd(CMD_PUSH_BACK, draw_value());
    issue_cmd(CMD_PUSH_BACK, draw_value());
    issue_cmd(CMD_PUSH_FRONT, draw_value());
    issue_cmd(CMD_POP_FRONT, draw_value());
    issue_cmd(CMD_POP_BACK, draw_value());
  endtask

  // Phases that lean toward filling, draining or neither, so the level sweeps its range.
  task automatic test_random_traffic(input int total);
    int         sent;
    int         phase;
    int         push_pct;
    int         pop_pct;
    int         len;
    int         r;
    logic [2:0] cmd;
    sent  = 0;
    phase = 0;
    while (sent < total) begin
      case (phase % 3)
        0:       begin push_pct = 70; pop_pct = 25; end
        1:       begin push_pct = 25; pop_pct = 70; end
        default: begin push_pct = 47; pop_pct = 47; end
      endcase
      if (phase % 5 == 0) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = $urandom_range(60, 5);
        rx_idle_pct = $urandom_range(60, 5);
      end
      len = $urandom_range(80, 20);
      repeat (len) begin
        r = $urandom_range(99);
        if (r < push_pct)
          cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else if (r < push_pct + pop_pct)
          cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        else if (r % 2 == 0)
          cmd = CMD_QUERY;
        else
          cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_QUERY + 1));
        issue_cmd(cmd, draw_value());
        sent++;
      end
      phase++;
    end
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_data  = '0;
    rsp_ready = 1'b0;
    head      = '0;
    fill      = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_queue();
    test_full_queue();
    test_random_traffic(1426);

    @(negedge clk);
    cmd_valid = 1'b0;
    while (due_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_status.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
